[design/phdd_pkg.sv]
// Shared constants, widths and state encoding for the heading PID drive block.
package phdd_pkg;

   localparam int unsigned DUTY_FULL  = 4096;
   localparam int unsigned SPEED_FULL = 254;
   localparam int unsigned MS_PER_S   = 1000;

   localparam int GAIN_W  = 24;
   localparam int HEAD_W  = 16;
   localparam int BASE_W  = 9;
   localparam int TS_W    = 32;
   localparam int ERR_W   = 17;
   localparam int DERR_W  = 18;
   localparam int INTEG_W = 48;
   localparam int DUTY_W  = 13;
   localparam int ENG_W   = 64;
   localparam int CNT_W   = 7;
   localparam int REQ_W   = 80;
   localparam int RSP_W   = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 24'd65536;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 24'd655;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 24'd13107;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RUN,
      S_ERRDT,
      S_INTEG,
      S_DK,
      S_DDIV,
      S_DRES,
      S_PMUL,
      S_PRES,
      S_IQ,
      S_IQK,
      S_IR,
      S_IRES,
      S_CORR,
      S_SIDE,
      S_DUTY
   } state_type;

   typedef enum logic {
      ENG_MUL,
      ENG_DIV
   } eng_op_type;

endpackage

[design/pid_heading_differential_drive.sv]
// Heading PID controller with differential-drive side mixing, bit-serial datapath.
//
// One request is taken at a time, and the next request can be accepted as soon
// as the result is registered. The work is done by a single shared shift-add
// multiplier / restoring divider that retires one bit per cycle over the chain
// err*dt, kd*de*1000/dt, kp*err, ki*integral/1000 and two duty divisions; the
// err*dt and derivative steps are skipped when the timestamp has not moved.
// The result sits in an output register, so the next request is accepted while
// a result still waits; a result that finds the output register still full
// waits there. Gains may be written only while the block is idle.
module pid_heading_differential_drive (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // target_heading, measured_heading, base_speed, timestamp_ms, zero pad
   input  logic [phdd_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // correction, right_backward, right_duty, left_backward, left_duty, zero pad
   output logic [phdd_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [phdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [phdd_pkg::GAIN_W-1:0]     csr_wdata
);
   import phdd_pkg::*;

   state_type state_ff, state_in, ret_ff, ret_in;
   eng_op_type op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ENG_W-1:0] acc_ff, acc_in, opa_ff, opa_in, opb_ff, opb_in;

   logic [GAIN_W-1:0] kp_ff, ki_ff, kd_ff;
   logic signed [ERR_W-1:0] last_err_ff, last_err_in, err_ff, err_in;
   logic signed [DERR_W-1:0] de_ff, de_in;
   logic [TS_W-1:0] last_ts_ff, last_ts_in, dt_ff, dt_in;
   logic signed [BASE_W-1:0] base_ff, base_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ENG_W-1:0] p_ff, p_in, d_ff, d_in, sum_ff, sum_in;
   logic [ENG_W-1:0] t_ff, t_in;
   logic signed [HEAD_W-1:0] corr_ff, corr_in;
   logic side_ff, side_in;
   logic back_ff, back_in;
   logic rb_ff, rb_in;
   logic [DUTY_W-1:0] rd_ff, rd_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [ERR_W-1:0] err_mag;
   logic [DERR_W-1:0] de_mag;
   logic [INTEG_W-1:0] integ_mag;
   logic [ENG_W:0] div_shift;
   logic signed [INTEG_W+2:0] isum, iprod;
   logic signed [ENG_W-1:0] ival, dq;
   logic [ENG_W-1:0] smag, iv;
   logic [INTEG_W-1:0] q16;
   logic signed [ERR_W-1:0] spd17;
   logic signed [HEAD_W-1:0] spd16;
   logic [HEAD_W-1:0] spd_mag;
   logic [ENG_W-1:0] duty_q;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign err_mag   = err_ff[ERR_W-1] ? -err_ff : err_ff;
   assign de_mag    = de_ff[DERR_W-1] ? -de_ff : de_ff;
   assign integ_mag = integ_ff[INTEG_W-1] ? -integ_ff : integ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= GAIN_P_RESET;
         ki_ff        <= GAIN_I_RESET;
         kd_ff        <= GAIN_D_RESET;
         last_err_ff  <= '0;
         last_ts_ff   <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
         last_ts_ff   <= last_ts_in;
         integ_ff     <= integ_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GAIN_P: kp_ff <= csr_wdata;
               CSR_GAIN_I: ki_ff <= csr_wdata;
               CSR_GAIN_D: kd_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      cnt_ff      <= cnt_in;
      acc_ff      <= acc_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      err_ff      <= err_in;
      de_ff       <= de_in;
      dt_ff       <= dt_in;
      base_ff     <= base_in;
      p_ff        <= p_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      corr_ff     <= corr_in;
      side_ff     <= side_in;
      back_ff     <= back_in;
      rb_ff       <= rb_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      err_in       = err_ff;
      de_in        = de_ff;
      dt_in        = dt_ff;
      base_in      = base_ff;
      last_err_in  = last_err_ff;
      last_ts_in   = last_ts_ff;
      integ_in     = integ_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      corr_in      = corr_ff;
      side_in      = side_ff;
      back_in      = back_ff;
      rb_in        = rb_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      div_shift = {acc_ff, opa_ff[ENG_W-1]};
      iprod     = '0;
      isum      = '0;
      ival      = '0;
      iv        = '0;
      dq        = '0;
      smag      = '0;
      q16       = '0;
      spd17     = '0;
      spd16     = '0;
      spd_mag   = '0;
      duty_q    = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               err_in = ERR_W'($signed(req_tdata[15:0])) - ERR_W'($signed(req_tdata[31:16]));
               de_in  = DERR_W'(err_in) - DERR_W'(last_err_ff);
               base_in = $signed(req_tdata[40:32]);
               dt_in  = req_tdata[72:41] - last_ts_ff;
               last_ts_in  = req_tdata[72:41];
               last_err_in = err_in;
               d_in = '0;
               state_in = (dt_in != '0) ? S_ERRDT : S_PMUL;
            end
         end
         S_RUN: begin
            if (op_ff == ENG_MUL) begin
               acc_in = opb_ff[0] ? acc_ff + opa_ff : acc_ff;
               opa_in = opa_ff << 1;
               opb_in = opb_ff >> 1;
            end else begin
               if (div_shift >= {1'b0, opb_ff}) begin
                  acc_in = ENG_W'(div_shift - {1'b0, opb_ff});
                  opa_in = {opa_ff[ENG_W-2:0], 1'b1};
               end else begin
                  acc_in = div_shift[ENG_W-1:0];
                  opa_in = {opa_ff[ENG_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) state_in = ret_ff;
         end
         S_ERRDT: begin
            op_in = ENG_MUL; acc_in = '0; opa_in = ENG_W'(dt_ff);
            opb_in = ENG_W'(err_mag); cnt_in = CNT_W'(ERR_W);
            ret_in = S_INTEG; state_in = S_RUN;
         end
         S_INTEG: begin
            iprod = err_ff[ERR_W-1] ? -$signed({2'b00, acc_ff[INTEG_W:0]})
                                    : $signed({2'b00, acc_ff[INTEG_W:0]});
            isum = (INTEG_W+3)'(integ_ff) + iprod;
            if (isum > (INTEG_W+3)'(signed'({1'b0, {(INTEG_W-1){1'b1}}})))
               integ_in = {1'b0, {(INTEG_W-1){1'b1}}};
            else if (isum < (INTEG_W+3)'(signed'({1'b1, {(INTEG_W-1){1'b0}}})))
               integ_in = {1'b1, {(INTEG_W-1){1'b0}}};
            else
               integ_in = isum[INTEG_W-1:0];
            op_in = ENG_MUL; acc_in = '0; opa_in = ENG_W'(kd_ff);
            opb_in = ENG_W'(de_mag); cnt_in = CNT_W'(DERR_W);
            ret_in = S_DK; state_in = S_RUN;
         end
         S_DK: begin
            op_in = ENG_MUL; opa_in = acc_ff; acc_in = '0;
            opb_in = ENG_W'(MS_PER_S); cnt_in = CNT_W'(10);
            ret_in = S_DDIV; state_in = S_RUN;
         end
         S_DDIV: begin
            op_in = ENG_DIV; opa_in = acc_ff; acc_in = '0;
            opb_in = ENG_W'(dt_ff); cnt_in = CNT_W'(ENG_W);
            ret_in = S_DRES; state_in = S_RUN;
         end
         S_DRES: begin
            dq = $signed(opa_ff);
            d_in = de_ff[DERR_W-1] ? -dq : dq;
            state_in = S_PMUL;
         end
         S_PMUL: begin
            op_in = ENG_MUL; acc_in = '0; opa_in = ENG_W'(kp_ff);
            opb_in = ENG_W'(err_mag); cnt_in = CNT_W'(ERR_W);
            ret_in = S_PRES; state_in = S_RUN;
         end
         S_PRES: begin
            p_in = err_ff[ERR_W-1] ? -$signed(acc_ff) : $signed(acc_ff);
            op_in = ENG_DIV; acc_in = '0; opa_in = ENG_W'(integ_mag);
            opb_in = ENG_W'(MS_PER_S); cnt_in = CNT_W'(ENG_W);
            ret_in = S_IQ; state_in = S_RUN;
         end
         S_IQ: begin
            t_in = acc_ff;
            op_in = ENG_MUL; acc_in = '0; opa_in = opa_ff;
            opb_in = ENG_W'(ki_ff); cnt_in = CNT_W'(GAIN_W);
            ret_in = S_IQK; state_in = S_RUN;
         end
         S_IQK: begin
            op_in = ENG_MUL; acc_in = '0; opa_in = ENG_W'(ki_ff);
            opb_in = t_ff; cnt_in = CNT_W'(10);
            t_in = acc_ff;
            ret_in = S_IR; state_in = S_RUN;
         end
         S_IR: begin
            op_in = ENG_DIV; opa_in = acc_ff; acc_in = '0;
            opb_in = ENG_W'(MS_PER_S); cnt_in = CNT_W'(ENG_W);
            ret_in = S_IRES; state_in = S_RUN;
         end
         S_IRES: begin
            iv = t_ff + opa_ff;
            ival = integ_ff[INTEG_W-1] ? -$signed(iv) : $signed(iv);
            sum_in = p_ff + d_ff + ival;
            state_in = S_CORR;
         end
         S_CORR: begin
            smag = sum_ff[ENG_W-1] ? -sum_ff : sum_ff;
            q16 = smag[ENG_W-1:16];
            if (!sum_ff[ENG_W-1])
               corr_in = (q16 > INTEG_W'(32767)) ? 16'sh7fff : $signed(q16[15:0]);
            else
               corr_in = (q16 > INTEG_W'(32768)) ? 16'sh8000 : -$signed(q16[15:0]);
            side_in = 1'b0;
            state_in = S_SIDE;
         end
         S_SIDE: begin
            spd17 = side_ff ? ERR_W'(base_ff) - ERR_W'(corr_ff)
                            : ERR_W'(base_ff) + ERR_W'(corr_ff);
            if (spd17 > 17'sd32767) spd16 = 16'sh7fff;
            else if (spd17 < -17'sd32768) spd16 = 16'sh8000;
            else spd16 = spd17[15:0];
            back_in = (spd16 <= 16'sd0);
            spd_mag = spd16[15] ? -spd16 : spd16;
            op_in = ENG_DIV; acc_in = '0;
            opa_in = ENG_W'(spd_mag) * ENG_W'(DUTY_FULL);
            opb_in = ENG_W'(SPEED_FULL); cnt_in = CNT_W'(ENG_W);
            ret_in = S_DUTY; state_in = S_RUN;
         end
         S_DUTY: begin
            duty_q = (opa_ff > ENG_W'(DUTY_FULL)) ? ENG_W'(DUTY_FULL) : opa_ff;
            if (!side_ff) begin
               rb_in = back_ff; rd_in = duty_q[DUTY_W-1:0];
               side_in = 1'b1; state_in = S_SIDE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'b0, duty_q[DUTY_W-1:0], back_ff, rd_ff, rb_ff, corr_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[design/phdd_checker.sv]
// Port-level checks for the heading PID drive block and their bind.
module phdd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [phdd_pkg::RSP_W-1:0]     rsp_tdata
);
   import phdd_pkg::*;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared without compute time");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[29:17] <= 13'(DUTY_FULL)) &&
                     (rsp_tdata[43:31] <= 13'(DUTY_FULL)))
      else $error("duty above full scale");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind pid_heading_differential_drive phdd_checker u_phdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/pid_heading_differential_drive_tb.sv]
// Testbench for the heading PID block with side mixing: directed, random, gain and stall tests.
`timescale 1ns / 100ps

module pid_heading_differential_drive_tb;
   import phdd_pkg::*;

   typedef struct packed {
      logic signed [15:0] correction;
      logic               right_backward;
      logic [12:0]        right_duty;
      logic               left_backward;
      logic [12:0]        left_duty;
   } drive_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [GAIN_W-1:0]      csr_wdata;

   pid_heading_differential_drive u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_LO = -INTEG_HI - 1;
   localparam int     DRAIN_CYCLES = 600;

   // predictor state and gains
   logic [GAIN_W-1:0] kp_m, ki_m, kd_m;
   longint            last_err_m;
   longint            integ_m;
   logic [31:0]       last_ts_m;

   drive_result_type  drive_expected_q[$];
   int                mismatch_count;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                rsp_hold_cycles;
   logic [31:0]       ts_now;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("pid_heading_differential_drive regression: fail");
      $finish;
   end

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void side_drive(input longint speed, output logic backward,
                                      output logic [12:0] duty);
      longint unsigned mag, d;
      speed = clamp(speed, -32768, 32767);
      backward = speed > 0 ? 1'b0 : 1'b1;
      mag = speed < 0 ? longint'(-speed) : longint'(speed);
      d = mag * DUTY_FULL / SPEED_FULL;
      if (d > DUTY_FULL)
         d = DUTY_FULL;
      duty = d[12:0];
   endfunction

   function automatic drive_result_type predict_drive(input logic signed [15:0] tgt,
                                                      input logic signed [15:0] meas,
                                                      input logic signed [8:0] base,
                                                      input logic [31:0] ts);
      drive_result_type r;
      logic [31:0] dt;
      longint err, de, dterm, pterm, iterm, sum, corr, dtl;
      longint unsigned mag, q, rem, t;
      dt = ts - last_ts_m;
      dtl = longint'({32'b0, dt});
      err = longint'(tgt) - longint'(meas);
      dterm = 0;
      if (dt != 0) begin
         de = err - last_err_m;
         integ_m = clamp(integ_m + err * dtl, INTEG_LO, INTEG_HI);
         dterm = (longint'({40'b0, kd_m}) * de * 1000) / dtl;
      end
      pterm = longint'({40'b0, kp_m}) * err;
      mag = integ_m < 0 ? longint'(-integ_m) : longint'(integ_m);
      q = mag / 1000;
      rem = mag % 1000;
      t = longint'({40'b0, ki_m}) * q + (longint'({40'b0, ki_m}) * rem) / 1000;
      iterm = integ_m < 0 ? -longint'(t) : longint'(t);
      sum = pterm + iterm + dterm;
      corr = clamp(sum / 65536, -32768, 32767);
      last_err_m = err;
      last_ts_m = ts;
      r.correction = corr[15:0];
      side_drive(longint'(base) + corr, r.right_backward, r.right_duty);
      side_drive(longint'(base) - corr, r.left_backward, r.left_duty);
      return r;
   endfunction

   task automatic send_request(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                               input logic signed [8:0] base, input logic [31:0] ts);
      while ($urandom_range(99) < send_idle_pct)
         @(negedge clock);
      req_tdata  <= {7'b0, ts, base, meas, tgt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      drive_expected_q.push_back(predict_drive(tgt, meas, base, ts));
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (drive_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GAIN_P: kp_m = val;
         CSR_GAIN_I: ki_m = val;
         default:    kd_m = val;
      endcase
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                            input logic [GAIN_W-1:0] d);
      wait_idle();
      write_gain(CSR_GAIN_P, p);
      write_gain(CSR_GAIN_I, i);
      write_gain(CSR_GAIN_D, d);
   endtask

   task automatic send_random_request();
      logic signed [15:0] tgt, meas;
      logic signed [8:0]  base;
      if ($urandom_range(3) == 0) begin
         tgt  = 16'($urandom);
         meas = 16'($urandom);
      end else begin
         tgt  = 16'($signed($urandom_range(720)) - 360);
         meas = 16'($signed($urandom_range(720)) - 360);
      end
      base = 9'($signed($urandom_range(510)) - 255);
      case ($urandom_range(9))
         0:       ts_now = $urandom;
         1:       ts_now = ts_now;
         default: ts_now = ts_now + $urandom_range(1, 40);
      endcase
      send_request(tgt, meas, base, ts_now);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(16'sd10, 16'sd0, 9'sd100, 32'd5);
      send_request(16'sd10, 16'sd0, 9'sd100, 32'd5);
      send_request(16'sd32767, -16'sd32768, 9'sd255, 32'd10);
      send_request(-16'sd32768, 16'sd32767, -9'sd255, 32'd20);
      send_request(16'sd0, 16'sd0, 9'sd0, 32'd30);
      send_request(16'sd0, 16'sd0, -9'sd1, 32'd31);
      send_request(16'sd0, 16'sd0, 9'sd1, 32'd32);
      send_request(16'sd0, 16'sd0, 9'sd254, 32'd33);
      send_request(16'sd90, 16'sd0, 9'sd50, 32'hFFFF_FFF0);
      send_request(16'sd90, 16'sd10, 9'sd50, 32'h0000_0010);
      send_request(16'sd32767, -16'sd32768, 9'sd0, 32'h8000_0010);
      send_request(16'sd32767, -16'sd32768, 9'sd0, 32'h0000_000F);
      send_request(16'sd32767, -16'sd32768, 9'sd0, 32'h8000_000E);
      send_request(-16'sd32768, 16'sd32767, 9'sd0, 32'h0000_000D);
      send_request(-16'sd32768, 16'sd32767, 9'sd0, 32'h8000_000C);
      send_request(-16'sd32768, 16'sd32767, 9'sd0, 32'h0000_000B);
      send_request(-16'sd32768, 16'sd32767, 9'sd0, 32'h8000_000A);
      send_request(16'sd5, 16'sd0, 9'sd0, 32'h8000_000B);
      ts_now = 32'h8000_000B;
   endtask

   task automatic test_random(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      repeat (n) send_random_request();
   endtask

   task automatic test_gains();
      set_gains('1, '1, '1);
      test_random(40, 0, 0);
      set_gains('0, '0, '0);
      test_random(20, 0, 0);
      set_gains(24'd65536 * 40, 24'd0, 24'hFFFFFF);
      test_random(30, 0, 0);
      set_gains(24'($urandom), 24'($urandom), 24'($urandom));
      test_random(30, 0, 0);
      set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(negedge clock);
      rsp_hold_cycles = 3000;
      repeat (8) send_random_request();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      drive_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[29:17], rsp_tdata[30],
                rsp_tdata[43:31]};
         if (drive_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            want = drive_expected_q.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: corr %0d/%0d r %b,%0d/%b,%0d l %b,%0d/%b,%0d",
                           want.correction, got.correction,
                           want.right_backward, want.right_duty,
                           got.right_backward, got.right_duty,
                           want.left_backward, want.left_duty,
                           got.left_backward, got.left_duty);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_GAIN_P;
      csr_wdata = '0;
      mismatch_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_cycles = 0;
      ts_now = '0;
      kp_m = GAIN_P_RESET;
      ki_m = GAIN_I_RESET;
      kd_m = GAIN_D_RESET;
      last_err_m = 0;
      integ_m = 0;
      last_ts_m = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_gains();
      test_random(420, 0, 0);
      test_backpressure();
      test_random(420, 85, 0);
      test_random(420, 0, 85);
      test_random(420, 37, 37);

      while (drive_expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (drive_expected_q.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0)
         $display("pid_heading_differential_drive regression: pass");
      else
         $display("pid_heading_differential_drive regression: fail");
      $finish;
   end

endmodule
